@@ sv/ocsp_pkg.sv @@
package ocsp_pkg;

  localparam logic signed [24:0] PI_Q      = 25'sd3294199;
  localparam logic signed [24:0] TWO_PI_Q  = 25'sd6588398;
  localparam logic signed [24:0] HALF_PI_Q = 25'sd1647099;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  // shared multiplier operand selects
  localparam logic [2:0] MOP_NONE = 3'd0;
  localparam logic [2:0] MOP_STEP = 3'd1;
  localparam logic [2:0] MOP_RCV  = 3'd2;
  localparam logic [2:0] MOP_RSV  = 3'd3;
  localparam logic [2:0] MOP_RCSU = 3'd4;
  localparam logic [2:0] MOP_RCCU = 3'd5;

  // product capture targets
  localparam logic [2:0] CAP_NONE = 3'd0;
  localparam logic [2:0] CAP_RC   = 3'd1;
  localparam logic [2:0] CAP_PY   = 3'd2;
  localparam logic [2:0] CAP_PX   = 3'd3;
  localparam logic [2:0] CAP_PZ   = 3'd4;

  localparam logic [1:0] REG_PIVOT_X    = 2'd0;
  localparam logic [1:0] REG_PIVOT_Y    = 2'd1;
  localparam logic [1:0] REG_PIVOT_Z    = 2'd2;
  localparam logic [1:0] REG_ZOOM_SPEED = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       upd;
    logic       cor_start;
    logic       cor_sel_el;
    logic       lat_az;
    logic       lat_el;
    logic [2:0] mul_op;
    logic [2:0] cap_op;
    logic       load_out;
  } ocsp_cmd_t;

  typedef struct packed {
    logic cor_done;
    logic out_free;
  } ocsp_stat_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;  5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;  5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sh007FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -38'sh0080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ sv/ocsp_cordic.sv @@
module ocsp_cordic #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [23:0]  angle,
  output logic                done,
  output logic signed [32:0]  sin_q,
  output logic signed [32:0]  cos_q
);
  import ocsp_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, neg_r, neg_nxt;
  logic signed [24:0] a_ext, a_fold;
  logic signed [33:0] xs, ys, at;

  always_comb begin
    a_ext = 25'(angle);
    a_fold = a_ext;
    if (a_ext > HALF_PI_Q) begin
      a_fold = a_ext - PI_Q;
    end else if (a_ext < -HALF_PI_Q) begin
      a_fold = a_ext + PI_Q;
    end
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = atan_q30(5'(cnt_r));
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r;
    if (start) begin
      x_nxt = CORDIC_GAIN;
      y_nxt = '0;
      z_nxt = {a_fold[23:0], 10'b0};
      neg_nxt = (a_ext > HALF_PI_Q) || (a_ext < -HALF_PI_Q);
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      busy_nxt = (cnt_r != CW'(CORDIC_STEPS - 1));
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign done  = !busy_r;
  assign sin_q = neg_r ? 33'(-y_r) : 33'(y_r);
  assign cos_q = neg_r ? 33'(-x_r) : 33'(x_r);

endmodule

@@ sv/ocsp_datapath.sv @@
module ocsp_datapath #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ocsp_pkg::ocsp_cmd_t  cmd,
  output ocsp_pkg::ocsp_stat_t stat,
  input  logic [63:0]          in_word,
  input  logic                 in_cmd,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [31:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [167:0]         out_word
);
  import ocsp_pkg::*;

  logic signed [31:0] pivx_r, pivy_r, pivz_r;
  logic [23:0]        zoom_r;
  logic signed [23:0] az_r, el_r, roll_r;
  logic signed [31:0] rad_r;
  logic [63:0]        inw_r;
  logic               inc_r;
  logic signed [32:0] su_r, cu_r, sv_r, cv_r;
  logic signed [66:0] prod_r;
  logic signed [33:0] rc_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic               ov_r;
  logic [167:0]       ow_r;

  logic               cor_done;
  logic signed [32:0] cor_s, cor_c;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic [26:0]        speed;
  logic [15:0]        dt;
  logic signed [24:0] da, az_t, roll_t, el_t;
  logic signed [33:0] step, r1, r2;
  logic signed [31:0] r1s;
  logic signed [37:0] acc_x, acc_y, acc_z;

  ocsp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cmd.cor_start),
    .angle(cmd.cor_sel_el ? el_r : az_r),
    .done(cor_done), .sin_q(cor_s), .cos_q(cor_c)
  );

  always_comb begin
    dt = inw_r[15:0];
    speed = inw_r[22] ? (27'(zoom_r) << 2) + 27'(zoom_r) : 27'(zoom_r);
    case (cmd.mul_op)
      MOP_STEP: begin mul_a = $signed({7'b0, speed}); mul_b = $signed({17'b0, dt}); end
      MOP_RCV:  begin mul_a = 34'(rad_r); mul_b = cv_r; end
      MOP_RSV:  begin mul_a = 34'(rad_r); mul_b = sv_r; end
      MOP_RCSU: begin mul_a = rc_r; mul_b = su_r; end
      MOP_RCCU: begin mul_a = rc_r; mul_b = cu_r; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase

    // angle and radius update; prod_r holds the zoom step product
    da = $signed({5'b0, dt, 4'b0});
    az_t = 25'(az_r) + (inw_r[16] ? da : 25'sd0) - (inw_r[17] ? da : 25'sd0);
    if (az_t >= PI_Q) az_t = az_t - TWO_PI_Q;
    if (az_t < -PI_Q) az_t = az_t + TWO_PI_Q;
    roll_t = 25'(roll_r) - (inw_r[18] ? da : 25'sd0) + (inw_r[19] ? da : 25'sd0);
    if (roll_t >= PI_Q) roll_t = roll_t - TWO_PI_Q;
    if (roll_t < -PI_Q) roll_t = roll_t + TWO_PI_Q;
    el_t = 25'(el_r) + (inw_r[20] ? da : 25'sd0) - (inw_r[21] ? da : 25'sd0);
    if (el_t >= HALF_PI_Q) el_t = HALF_PI_Q;
    if (el_t <= -HALF_PI_Q) el_t = -HALF_PI_Q;
    step = $signed({7'b0, prod_r[42:16]});
    r1 = 34'(rad_r) - (inw_r[23] ? step : 34'sd0);
    r1s = sat32(38'(r1));
    r2 = 34'(r1s) + (inw_r[24] ? step : 34'sd0);

    acc_x = 38'(pivx_r) + 38'($signed(prod_r[66:30]));
    acc_y = 38'(pivy_r) + 38'($signed(prod_r[66:30]));
    acc_z = 38'(pivz_r) + 38'($signed(prod_r[66:30]));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      inw_r <= in_word;
      inc_r <= in_cmd;
    end
    if (cmd.lat_az) begin
      su_r <= cor_s;
      cu_r <= cor_c;
    end
    if (cmd.lat_el) begin
      sv_r <= cor_s;
      cv_r <= cor_c;
    end
    prod_r <= mul_a * mul_b;
    case (cmd.cap_op)
      CAP_RC:  rc_r <= prod_r[63:30];
      CAP_PY:  py_r <= sat32(acc_y);
      CAP_PX:  px_r <= sat32(acc_x);
      CAP_PZ:  pz_r <= sat32(acc_z);
      default: ;
    endcase
    if (cmd.load_out) begin
      ow_r <= {roll_r, az_r, 24'(-el_r), pz_r, py_r, px_r};
    end
    if (!rst_n) begin
      pivx_r <= '0; pivy_r <= '0; pivz_r <= '0;
      zoom_r <= 24'd65536;
      az_r <= '0; el_r <= '0; roll_r <= '0; rad_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PIVOT_X:    pivx_r <= cfg_wdata;
          REG_PIVOT_Y:    pivy_r <= cfg_wdata;
          REG_PIVOT_Z:    pivz_r <= cfg_wdata;
          REG_ZOOM_SPEED: zoom_r <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (cmd.upd) begin
        if (inc_r) begin
          az_r <= '0; el_r <= '0; roll_r <= '0;
          rad_r <= inw_r[56:25];
        end else begin
          az_r <= az_t[23:0];
          el_r <= el_t[23:0];
          roll_r <= roll_t[23:0];
          rad_r <= sat32(38'(r2));
        end
      end
      if (cmd.load_out) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign stat.cor_done = cor_done;
  assign stat.out_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_word = ow_r;

endmodule

@@ sv/ocsp_ctrl.sv @@
module ocsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ocsp_pkg::ocsp_stat_t stat,
  output ocsp_pkg::ocsp_cmd_t  cmd
);
  import ocsp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_STEP = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_CAZ  = 4'd3;
  localparam logic [3:0] S_WAZ  = 4'd4;
  localparam logic [3:0] S_CEL  = 4'd5;
  localparam logic [3:0] S_WEL  = 4'd6;
  localparam logic [3:0] S_M0   = 4'd7;
  localparam logic [3:0] S_M1   = 4'd8;
  localparam logic [3:0] S_M2   = 4'd9;
  localparam logic [3:0] S_M3   = 4'd10;
  localparam logic [3:0] S_M4   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin cmd.mul_op = MOP_STEP; state_nxt = S_UPD; end
      S_UPD:  begin cmd.upd = 1'b1; state_nxt = S_CAZ; end
      S_CAZ:  begin cmd.cor_start = 1'b1; state_nxt = S_WAZ; end
      S_WAZ: begin
        if (stat.cor_done) begin
          cmd.lat_az = 1'b1;
          state_nxt = S_CEL;
        end
      end
      S_CEL: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel_el = 1'b1;
        state_nxt = S_WEL;
      end
      S_WEL: begin
        if (stat.cor_done) begin
          cmd.lat_el = 1'b1;
          state_nxt = S_M0;
        end
      end
      S_M0: begin cmd.mul_op = MOP_RCV; state_nxt = S_M1; end
      S_M1: begin cmd.cap_op = CAP_RC; cmd.mul_op = MOP_RSV; state_nxt = S_M2; end
      S_M2: begin cmd.cap_op = CAP_PY; cmd.mul_op = MOP_RCSU; state_nxt = S_M3; end
      S_M3: begin cmd.cap_op = CAP_PX; cmd.mul_op = MOP_RCCU; state_nxt = S_M4; end
      S_M4: begin cmd.cap_op = CAP_PZ; state_nxt = S_OUT; end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/orbit_camera_spherical_pose.sv @@
// Orbit camera pose unit. Each input word either steps the camera (command 0:
// azimuth, roll and elevation move by delta_time per held key, elevation is
// clamped to +-pi/2, distance moves by zoom_speed * delta_time, five times that
// with key_fast) or resets it (command 1: angles to zero, distance loaded from
// new_distance). Every input word yields exactly one output word carrying the
// position pivot + distance * (sin az cos el, sin el, cos az cos el) in signed
// Q16.16, saturated, and the rotation (-el, az, roll) in Q3.20 radians. The
// time per word is set by the iterative CORDIC that is run twice and the one
// shared multiplier used five times; a finished word waits in the output
// register while the next input word is taken. Configuration writes are
// always accepted and must be issued only while no word is in flight.
module orbit_camera_spherical_pose #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata fields, low bit up: delta_time[15:0], key_right, key_left,
  // key_roll_down, key_roll_up, key_up, key_down, key_fast, key_zoom_in,
  // key_zoom_out, new_distance[31:0], zero fill
  input  logic [63:0]  in_tdata,
  // tuser fields: command
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata fields, low bit up: pos_x, pos_y, pos_z, rot_x, rot_y, rot_z
  output logic [167:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ocsp_pkg::*;

  ocsp_cmd_t  cmd;
  ocsp_stat_t stat;

  assign cfg_ready = 1'b1;

  ocsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  ocsp_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_word(in_tdata), .in_cmd(in_tuser[0]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_word(out_tdata)
  );

endmodule

@@ tb/orbit_camera_spherical_pose_tb.sv @@
module orbit_camera_spherical_pose_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ocsp_pkg::*;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_RESET = 1'b1;
  localparam int   STEPS     = 20;
  localparam longint PI_L    = 3294199;
  localparam longint HPI_L   = 1647099;
  localparam longint GAIN_L  = 64'h26DD3B6A;
  localparam int   CYCLE_LIMIT = 1000000;
  localparam int   SETTLE    = 120;

  // key bits inside the frame word, low bit up
  localparam int K_RIGHT = 0, K_LEFT = 1, K_RDOWN = 2, K_RUP = 3, K_UP = 4,
                 K_DOWN = 5, K_FAST = 6, K_ZIN = 7, K_ZOUT = 8;

  localparam longint ATAN_Q30 [0:STEPS-1] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF};

  typedef struct {
    logic        cmd;
    logic [15:0] dt;
    logic [8:0]  keys;
    logic [31:0] new_dist;
  } cam_word_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [23:0] rx, ry, rz;
  } pose_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  orbit_camera_spherical_pose u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data));

  initial begin
    forever #5 clk = ~clk;
  end

  // camera state mirror and register copies
  longint m_pivot_x = 0, m_pivot_y = 0, m_pivot_z = 0, m_zoom = 65536;
  longint m_az = 0, m_el = 0, m_roll = 0, m_radius = 0;

  cam_word_t pending_words[$];
  pose_t     expected_poses[$];
  int        errors = 0;
  int        words_sent = 0, poses_seen = 0, resets_sent = 0;
  bit        no_idle = 0;
  longint    cycles = 0;

  function automatic longint sat_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap_pi(longint a);
    if (a >= PI_L) a -= 2 * PI_L;
    if (a < -PI_L) a += 2 * PI_L;
    return a;
  endfunction

  // rotation-mode CORDIC, angle folded into the right half plane first
  task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
    bit     flip;
    longint x, y, z, nx;
    flip = 0;
    x = GAIN_L;
    y = 0;
    if (ang > HPI_L) begin
      ang -= PI_L; flip = 1;
    end else if (ang < -HPI_L) begin
      ang += PI_L; flip = 1;
    end
    z = ang * 1024;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q30[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  // advance the camera by one word and return the pose it reports
  task automatic advance_camera(input cam_word_t w, output pose_t p);
    longint da, speed, zstep, su, cu, sv, cv, rc;
    if (w.cmd == CMD_RESET) begin
      m_az = 0; m_el = 0; m_roll = 0;
      m_radius = longint'($signed(w.new_dist));
    end else begin
      da = longint'(w.dt) * 16;
      speed = m_zoom;
      if (w.keys[K_RIGHT]) m_az += da;
      if (w.keys[K_LEFT])  m_az -= da;
      m_az = wrap_pi(m_az);
      if (w.keys[K_RDOWN]) m_roll -= da;
      if (w.keys[K_RUP])   m_roll += da;
      m_roll = wrap_pi(m_roll);
      if (w.keys[K_UP])   m_el += da;
      if (w.keys[K_DOWN]) m_el -= da;
      if (m_el >= HPI_L)  m_el = HPI_L;
      if (m_el <= -HPI_L) m_el = -HPI_L;
      if (w.keys[K_FAST]) speed *= 5;
      zstep = (speed * longint'(w.dt)) >>> 16;
      // zoom in first, then out, each saturating
      if (w.keys[K_ZIN])  m_radius = sat_q16(m_radius - zstep);
      if (w.keys[K_ZOUT]) m_radius = sat_q16(m_radius + zstep);
    end
    cordic_sin_cos(m_az, su, cu);
    cordic_sin_cos(m_el, sv, cv);
    rc = (m_radius * cv) >>> 30;
    p.px = 32'(sat_q16(m_pivot_x + ((rc * su) >>> 30)));
    p.py = 32'(sat_q16(m_pivot_y + ((m_radius * sv) >>> 30)));
    p.pz = 32'(sat_q16(m_pivot_z + ((rc * cu) >>> 30)));
    p.rx = 24'(-m_el);
    p.ry = 24'(m_az);
    p.rz = 24'(m_roll);
  endtask

  // reset: hold low, then release on a falling edge
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // input driver: present the head word, hold it until taken, then gap
  int  in_gap = 0;
  bit  in_taken = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_tdata  <= {7'b0, pending_words[0].new_dist, pending_words[0].keys,
                      pending_words[0].dt};
        in_tuser  <= pending_words[0].cmd;
        in_tvalid <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_tvalid <= 1'b0;
      end
      in_taken = 0;
    end
  end

  // take the accepted word, predict its pose
  always @(posedge clk) begin
    pose_t p;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      advance_camera(pending_words[0], p);
      expected_poses.push_back(p);
      if (pending_words[0].cmd == CMD_RESET) resets_sent++;
      void'(pending_words.pop_front());
      words_sent++;
      in_taken = 1;
    end
  end

  // result side stalls
  int out_stall = 0;
  bit out_taken = 0;
  always @(negedge clk) begin
    if (out_taken) begin
      out_stall = no_idle ? 0 : $urandom_range(0, 3);
      out_taken = 0;
    end
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each accepted pose with the oldest prediction
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_tvalid && out_tready) begin
      out_taken = 1;
      poses_seen++;
      if (expected_poses.size() == 0) begin
        $error("pose word with no prediction pending: %h", out_tdata);
        errors++;
      end else begin
        e = expected_poses.pop_front();
        if (out_tdata[31:0] !== e.px) begin
          $error("pos_x expected %h got %h", e.px, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== e.py) begin
          $error("pos_y expected %h got %h", e.py, out_tdata[63:32]); errors++;
        end
        if (out_tdata[95:64] !== e.pz) begin
          $error("pos_z expected %h got %h", e.pz, out_tdata[95:64]); errors++;
        end
        if (out_tdata[119:96] !== e.rx) begin
          $error("rot_x expected %h got %h", e.rx, out_tdata[119:96]); errors++;
        end
        if (out_tdata[143:120] !== e.ry) begin
          $error("rot_y expected %h got %h", e.ry, out_tdata[143:120]); errors++;
        end
        if (out_tdata[167:144] !== e.rz) begin
          $error("rot_z expected %h got %h", e.rz, out_tdata[167:144]); errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIVOT_X:    m_pivot_x = longint'($signed(val));
      REG_PIVOT_Y:    m_pivot_y = longint'($signed(val));
      REG_PIVOT_Z:    m_pivot_z = longint'($signed(val));
      REG_ZOOM_SPEED: m_zoom = longint'(val[23:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain the pipe, then let the last word settle before touching registers
  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_poses.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_word(input logic c, input logic [15:0] dt,
                            input logic [8:0] keys, input logic [31:0] new_dist);
    cam_word_t w;
    w.cmd = c; w.dt = dt; w.keys = keys; w.new_dist = new_dist;
    pending_words.push_back(w);
  endtask

  // mostly key frames with random content, some resets
  task automatic queue_random(input int n);
    logic [31:0] d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: d = 32'h7FFFFFFF;
          1: d = 32'h80000000;
          2: d = $urandom_range(0, 32'h00400000);
          default: d = $urandom;
        endcase
        queue_word(CMD_RESET, 16'($urandom), 9'($urandom), d);
      end else begin
        queue_word(CMD_FRAME, 16'($urandom), 9'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    wait (rst_n);
    repeat (4) @(posedge clk);

    // directed: extremes, each key alone, paired keys, wrap, clamp, saturation
    queue_word(CMD_RESET, 16'hFFFF, 9'h1FF, 32'h0000_0000);
    queue_word(CMD_RESET, 16'h0000, 9'h000, 32'h0005_0000);
    queue_word(CMD_FRAME, 16'h0000, 9'h1FF, 32'hFFFF_FFFF);
    for (int k = 0; k < 9; k++)
      queue_word(CMD_FRAME, 16'h4000, 9'(1 << k), 32'h0);
    queue_word(CMD_FRAME, 16'hFFFF, 9'b000111111, 32'h0); // all pairs cancel
    // spin azimuth and roll past pi, push elevation into its upper limit
    repeat (4) queue_word(CMD_FRAME, 16'hFFFF, 9'b000011001, 32'h0);
    repeat (2) queue_word(CMD_FRAME, 16'hFFFF, 9'b000100010, 32'h0);
    // radius saturation both ways, negative radius kept
    queue_word(CMD_RESET, 16'h0, 9'h0, 32'h7FFF_0000);
    queue_word(CMD_FRAME, 16'hFFFF, 9'b101000000, 32'h0);
    queue_word(CMD_RESET, 16'h0, 9'h0, 32'h8000_1000);
    queue_word(CMD_FRAME, 16'hFFFF, 9'b011000000, 32'h0);
    queue_word(CMD_FRAME, 16'h8000, 9'b010000000, 32'h0);
    queue_random(300);
    wait_drained();

    // largest pivot and zoom speed: position and radius saturate easily
    write_reg(REG_PIVOT_X, 32'h7FFF_FFFF);
    write_reg(REG_PIVOT_Y, 32'h8000_0000);
    write_reg(REG_PIVOT_Z, 32'h7FFF_FFFF);
    write_reg(REG_ZOOM_SPEED, 32'h00FF_FFFF);
    no_idle = 1;
    queue_word(CMD_RESET, 16'h0, 9'h0, 32'h7FFF_FFFF);
    queue_random(300);
    wait_drained();

    // zero zoom speed, opposite pivot corners
    write_reg(REG_PIVOT_X, 32'h8000_0000);
    write_reg(REG_PIVOT_Y, 32'h7FFF_FFFF);
    write_reg(REG_PIVOT_Z, 32'h8000_0000);
    write_reg(REG_ZOOM_SPEED, 32'h0000_0000);
    no_idle = 0;
    queue_random(300);
    wait_drained();

    // random setting of all four registers
    write_reg(REG_PIVOT_X, $urandom);
    write_reg(REG_PIVOT_Y, $urandom);
    write_reg(REG_PIVOT_Z, $urandom);
    write_reg(REG_ZOOM_SPEED, $urandom_range(0, 24'hFFFFFF));
    queue_random(330);
    wait_drained();

    $display("covered %0d camera words (%0d resets), %0d poses checked, 4 register sets",
             words_sent, resets_sent, poses_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ocsp_pkg.sv
sv/ocsp_cordic.sv
sv/ocsp_datapath.sv
sv/ocsp_ctrl.sv
sv/orbit_camera_spherical_pose.sv
tb/orbit_camera_spherical_pose_tb.sv
